/* hdl/bmh_pkg.sv */
// Shared constants and types for the binary max-heap sorter.
`timescale 1ns / 1ps

package bmh_pkg;

    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

    typedef logic signed [DATA_W-1:0] t_value;
    typedef logic [CNT_W-1:0]         t_count;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

/* hdl/binary_max_heap_sorter.sv */
// Top level of the max-heap sorter: sorted cell row, load/drain control, stream ports.
//
//  channel  | direction | tdata               | tlast     | tuser
//  s_axis   | in        | [31:0] value        | is_last   | -
//  m_axis   | out       | [31:0] sorted_value | final_res | [0] overflowed
//
// Load takes one item per cycle; up to DEPTH values are registered into place in the cell
// row, later ones are dropped. After an item with tlast, one result leaves per cycle while
// m_axis is ready, largest first, as the row shifts toward its head; no input is taken
// until the final result is accepted. Reset (synchronous, active low) empties the row and
// clears the overflow flag. A stalled m_axis holds the row and the current result.
`timescale 1ns / 1ps

module binary_max_heap_sorter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [bmh_pkg::TDATA_W-1:0] i_s_axis_tdata,  // [31:0] value
    input  logic                        i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [bmh_pkg::TDATA_W-1:0] o_m_axis_tdata,  // [31:0] sorted_value
    output logic                        o_m_axis_tlast,
    output logic                        o_m_axis_tuser   // [0] overflowed
);
    import bmh_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    t_state     r_state;
    t_count     r_count;
    logic       r_overflow;

    t_value     w_value;
    t_cell_ctrl w_ctrl;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_full;
    t_value     w_val  [DEPTH];
    logic       w_keep [DEPTH];

    assign w_value   = t_value'(i_s_axis_tdata[DATA_W-1:0]);
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign w_full    = (r_count == t_count'(DEPTH));

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.shift  = w_out_acc;

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            t_value w_prev_val;
            logic   w_prev_keep;
            t_value w_next_val;
            logic   w_occ;

            assign w_occ = (t_count'(g) < r_count);

            if (g == 0) begin : g_head
                assign w_prev_val  = w_value;
                assign w_prev_keep = 1'b1;
            end else begin : g_body
                assign w_prev_val  = w_val[g-1];
                assign w_prev_keep = w_keep[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_next_val = w_val[g];
            end else begin : g_mid
                assign w_next_val = w_val[g+1];
            end

            bmh_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_value     (w_value),
                .i_occupied  (w_occ),
                .i_prev_val  (w_prev_val),
                .i_prev_keep (w_prev_keep),
                .i_next_val  (w_next_val),
                .o_val       (w_val[g]),
                .o_keep      (w_keep[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (w_full) begin
                            r_overflow <= 1'b1;
                        end else begin
                            r_count <= r_count + t_count'(1);
                        end
                        if (i_s_axis_tlast) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_out_acc) begin
                        r_count <= r_count - t_count'(1);
                        if (r_count == t_count'(1)) begin
                            r_overflow <= 1'b0;
                            r_state    <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign o_m_axis_tvalid = (r_state == ST_DRAIN);
    assign o_m_axis_tdata  = TDATA_W'(unsigned'(w_val[0]));
    assign o_m_axis_tlast  = (r_count == t_count'(1));
    assign o_m_axis_tuser  = r_overflow;

endmodule

/* hdl/bmh_cell.sv */
// One storage cell of the sorted row: holds a value, inserts or shifts toward the head.
`timescale 1ns / 1ps

module bmh_cell (
    input  logic                i_clk,
    input  bmh_pkg::t_cell_ctrl i_ctrl,
    input  bmh_pkg::t_value     i_value,
    input  logic                i_occupied,
    input  bmh_pkg::t_value     i_prev_val,
    input  logic                i_prev_keep,
    input  bmh_pkg::t_value     i_next_val,
    output bmh_pkg::t_value     o_val,
    output logic                o_keep
);
    import bmh_pkg::*;

    t_value r_val;
    t_value n_val;

    assign o_keep = i_occupied && (r_val >= i_value);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.shift) begin
            n_val = i_next_val;
        end else if (i_ctrl.insert && !o_keep) begin
            n_val = i_prev_keep ? i_value : i_prev_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* hdl/bmh_checker.sv */
// Port-level assertions for the max-heap sorter, bound to the top level.
`timescale 1ns / 1ps

module bmh_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic [bmh_pkg::TDATA_W-1:0] i_s_axis_tdata,
    input logic                        i_s_axis_tlast,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [bmh_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input logic                        o_m_axis_tlast,
    input logic                        o_m_axis_tuser
);
    import bmh_pkg::*;

    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while results pending");

    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tlast) |=> o_m_axis_tvalid)
        else $error("no result after last input transaction");

    a_final_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_axis_tlast) |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("drain did not end after final result");

    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_m_axis_tlast) |=>
        (o_m_axis_tvalid &&
         ($signed(o_m_axis_tdata[DATA_W-1:0]) <= $signed($past(o_m_axis_tdata[DATA_W-1:0])))))
        else $error("results not in descending order");

    a_flag_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && $past(o_m_axis_tvalid)) |-> $stable(o_m_axis_tuser))
        else $error("overflow flag changed within a run");

endmodule

bind binary_max_heap_sorter bmh_checker u_bmh_checker (.*);
